FILE: design/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define XTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define XTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define XTP_ASSERT(lbl, prop, msg)
`define XTP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/xtp_pkg.sv
// Shared types, character constants and match helpers for the XHTML text filter.
`default_nettype none
package xtp_pkg;

  // Tag name store depth and flattened name width
  localparam int NAME_DEPTH = 11;
  localparam int NAME_W     = 8 * NAME_DEPTH;
  // Leading entity bytes that take part in named matching
  localparam int ENT_NAME_CHARS = 6;

  // One result transaction
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        byte_valid;
    logic [23:0] words;
    logic        end_of_text;
  } xtp_result_t;

  // Results caused by one input byte, in order
  typedef struct packed {
    logic [1:0]  count;
    xtp_result_t r0;
    xtp_result_t r1;
  } xtp_emit_t;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_AMP   = "&";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_QUOT  = "\"";
  localparam logic [7:0] CH_APOS  = "'";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Tag names, right-justified
  localparam logic [NAME_W-1:0] NM_SCRIPT = NAME_W'("script");
  localparam logic [NAME_W-1:0] NM_STYLE  = NAME_W'("style");
  localparam logic [NAME_W-1:0] NM_BR     = NAME_W'("br");
  localparam logic [NAME_W-1:0] NM_P      = NAME_W'("/p");
  localparam logic [NAME_W-1:0] NM_DIV    = NAME_W'("/div");
  localparam logic [NAME_W-1:0] NM_H1     = NAME_W'("/h1");
  localparam logic [NAME_W-1:0] NM_H2     = NAME_W'("/h2");
  localparam logic [NAME_W-1:0] NM_H3     = NAME_W'("/h3");
  localparam logic [NAME_W-1:0] NM_H4     = NAME_W'("/h4");
  localparam logic [NAME_W-1:0] NM_H5     = NAME_W'("/h5");
  localparam logic [NAME_W-1:0] NM_H6     = NAME_W'("/h6");
  localparam logic [NAME_W-1:0] NM_LI     = NAME_W'("/li");
  localparam logic [NAME_W-1:0] NM_TR     = NAME_W'("/tr");
  localparam logic [NAME_W-1:0] NM_BQ     = NAME_W'("/blockquote");

  // Named entities, right-justified
  localparam logic [NAME_W-1:0] EN_AMP    = NAME_W'("amp");
  localparam logic [NAME_W-1:0] EN_LT     = NAME_W'("lt");
  localparam logic [NAME_W-1:0] EN_GT     = NAME_W'("gt");
  localparam logic [NAME_W-1:0] EN_NBSP   = NAME_W'("nbsp");
  localparam logic [NAME_W-1:0] EN_QUOT   = NAME_W'("quot");
  localparam logic [NAME_W-1:0] EN_APOS   = NAME_W'("apos");
  localparam logic [NAME_W-1:0] EN_MDASH  = NAME_W'("mdash");
  localparam logic [NAME_W-1:0] EN_NDASH  = NAME_W'("ndash");
  localparam logic [NAME_W-1:0] EN_LSQUO  = NAME_W'("lsquo");
  localparam logic [NAME_W-1:0] EN_RSQUO  = NAME_W'("rsquo");
  localparam logic [NAME_W-1:0] EN_LDQUO  = NAME_W'("ldquo");
  localparam logic [NAME_W-1:0] EN_RDQUO  = NAME_W'("rdquo");
  localparam logic [NAME_W-1:0] EN_HELLIP = NAME_W'("hellip");

  // Close patterns of skipped bodies, first byte at index 0
  localparam logic [2:0] SCRIPT_CLOSE_LEN = 3'd7;
  localparam logic [2:0] STYLE_CLOSE_LEN  = 3'd6;
  localparam logic [7:0] SCRIPT_PAT [7] = '{"/", "s", "c", "r", "i", "p", "t"};
  localparam logic [7:0] STYLE_PAT  [7] = '{"/", "s", "t", "y", "l", "e", 8'h00};

  // Numeric entity code points
  localparam logic [16:0] NUM_SAT   = 17'h1FFFF;
  localparam logic [16:0] CP_LSQUO  = 17'h02018;
  localparam logic [16:0] CP_RSQUO  = 17'h02019;
  localparam logic [16:0] CP_LDQUO  = 17'h0201C;
  localparam logic [16:0] CP_RDQUO  = 17'h0201D;
  localparam logic [16:0] CP_NDASH  = 17'h02013;
  localparam logic [16:0] CP_MDASH  = 17'h02014;
  localparam logic [16:0] CP_HELLIP = 17'h02026;
  localparam logic [16:0] CP_NBSP   = 17'h000A0;
  localparam logic [16:0] CP_PRINT_LO = 17'd32;
  localparam logic [16:0] CP_PRINT_HI = 17'd127;

  // Lower-case an ASCII letter
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CH_UA:CH_UZ]}) r = c + 8'd32;
    return r;
  endfunction

  // Exact match of a stored name (byte k at bits 8k) against a right-justified pattern
  function automatic logic name_match(input logic [NAME_W-1:0] flat, input int len,
                                      input logic [NAME_W-1:0] pat, input int n);
    logic ok;
    int   j;
    ok = (len == n);
    for (int k = 0; k < NAME_DEPTH; k++) begin
      if (k < n) begin
        j = n - 1 - k;
        if (flat[8*k +: 8] != pat[8*j +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

FILE: design/xtp_parser.sv
// Parser state and per-byte decode: tags, skipped bodies, entities, spacing, word count.
`default_nettype none
`include "assert_macros.svh"
module xtp_parser
  import xtp_pkg::*;
#(
  parameter int ENTITY_MAX      = 15,
  parameter int WORD_COUNT_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_final,
  output xtp_emit_t       emit
);

  localparam int ENT_LEN_W = $clog2(ENTITY_MAX + 1);
  localparam int ENT_IDX_W = $clog2(ENTITY_MAX);

  // Parse modes
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_TAG     = 3'd1;
  localparam logic [2:0] MODE_SCRIPT  = 3'd2;
  localparam logic [2:0] MODE_STYLE   = 3'd3;
  localparam logic [2:0] MODE_ENTITY  = 3'd4;
  localparam logic [2:0] MODE_SKIP_GT = 3'd5;

  // Tag phases
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_NAME = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Last emitted class
  localparam logic [1:0] LAST_TEXT  = 2'd0;
  localparam logic [1:0] LAST_SPACE = 2'd1;
  localparam logic [1:0] LAST_NL    = 2'd2;

  logic [2:0]                 mode_r, mode_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [7:0]                 tag_chars_r [NAME_DEPTH];
  logic [3:0]                 tag_len_r, tag_len_nxt;
  logic                       too_long_r, too_long_nxt;
  logic [2:0]                 cpos_r, cpos_nxt;
  logic [7:0]                 ent_chars_r [ENTITY_MAX];
  logic [ENT_LEN_W-1:0]       ent_len_r, ent_len_nxt;
  logic [16:0]                num_r, num_nxt;
  logic                       num_done_r, num_done_nxt;
  logic [1:0]                 last_r, last_nxt;
  logic                       in_word_r, in_word_nxt;
  logic [WORD_COUNT_BITS-1:0] wt_r, wt_nxt;

  logic              tag_we, ent_we;
  logic [7:0]        c_lo;
  logic [NAME_W-1:0] tag_flat, ent_flat;
  logic              is_script, is_style, is_break;
  logic [7:0]        dec;
  logic              hex, is_x, dig_ok;
  logic [3:0]        dig_val;
  logic [7:0]        dig_tmp;
  logic [21:0]       num_prod, num_sum;
  logic [7:0]        close_ch;
  logic [2:0]        close_len;
  logic [2:0]        close_idx;
  logic              do_word, do_space, do_nl;
  logic              p_v, t_v;
  logic [7:0]        p_b, t_b, wbyte;
  logic [31:0]       wt_ext;
  xtp_result_t       r_p, r_t;

  assign c_lo = to_lower(in_byte);

  // Flatten the name stores for matching
  always_comb begin
    tag_flat = '0;
    ent_flat = '0;
    for (int k = 0; k < NAME_DEPTH; k++) tag_flat[8*k +: 8] = tag_chars_r[k];
    for (int k = 0; k < ENT_NAME_CHARS; k++) ent_flat[8*k +: 8] = ent_chars_r[k];
  end

  // Classify the held tag name
  always_comb begin
    is_script = !too_long_r && name_match(tag_flat, int'(tag_len_r), NM_SCRIPT, 6);
    is_style  = !too_long_r && name_match(tag_flat, int'(tag_len_r), NM_STYLE, 5);
    is_break  = !too_long_r && (
                name_match(tag_flat, int'(tag_len_r), NM_BR, 2)  ||
                name_match(tag_flat, int'(tag_len_r), NM_P, 2)   ||
                name_match(tag_flat, int'(tag_len_r), NM_DIV, 4) ||
                name_match(tag_flat, int'(tag_len_r), NM_H1, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_H2, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_H3, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_H4, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_H5, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_H6, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_LI, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_TR, 3)  ||
                name_match(tag_flat, int'(tag_len_r), NM_BQ, 11));
  end

  // Decode the held entity to one byte, zero for nothing
  always_comb begin
    dec = CH_NUL;
    if (ent_len_r != '0 && ent_chars_r[0] == CH_HASH) begin
      if (num_r >= CP_PRINT_LO && num_r < CP_PRINT_HI) dec = num_r[7:0];
      else if (num_r == CP_LSQUO || num_r == CP_RSQUO) dec = CH_APOS;
      else if (num_r == CP_LDQUO || num_r == CP_RDQUO) dec = CH_QUOT;
      else if (num_r == CP_NDASH || num_r == CP_MDASH) dec = CH_DASH;
      else if (num_r == CP_HELLIP) dec = CH_DOT;
      else if (num_r == CP_NBSP) dec = CH_SPACE;
    end
    if (name_match(ent_flat, int'(ent_len_r), EN_AMP, 3))    dec = CH_AMP;
    if (name_match(ent_flat, int'(ent_len_r), EN_LT, 2))     dec = CH_LT;
    if (name_match(ent_flat, int'(ent_len_r), EN_GT, 2))     dec = CH_GT;
    if (name_match(ent_flat, int'(ent_len_r), EN_NBSP, 4))   dec = CH_SPACE;
    if (name_match(ent_flat, int'(ent_len_r), EN_QUOT, 4))   dec = CH_QUOT;
    if (name_match(ent_flat, int'(ent_len_r), EN_APOS, 4))   dec = CH_APOS;
    if (name_match(ent_flat, int'(ent_len_r), EN_MDASH, 5))  dec = CH_DASH;
    if (name_match(ent_flat, int'(ent_len_r), EN_NDASH, 5))  dec = CH_DASH;
    if (name_match(ent_flat, int'(ent_len_r), EN_LSQUO, 5))  dec = CH_APOS;
    if (name_match(ent_flat, int'(ent_len_r), EN_RSQUO, 5))  dec = CH_APOS;
    if (name_match(ent_flat, int'(ent_len_r), EN_LDQUO, 5))  dec = CH_QUOT;
    if (name_match(ent_flat, int'(ent_len_r), EN_RDQUO, 5))  dec = CH_QUOT;
    if (name_match(ent_flat, int'(ent_len_r), EN_HELLIP, 6)) dec = CH_DOT;
  end

  // Digit value of the incoming byte and the next numeric value
  always_comb begin
    is_x    = (in_byte == CH_LX) || (in_byte == CH_UX);
    hex     = (ent_len_r >= ENT_LEN_W'(2)) &&
              (ent_chars_r[1] == CH_LX || ent_chars_r[1] == CH_UX);
    dig_ok  = 1'b0;
    dig_tmp = 8'd0;
    if (in_byte inside {[CH_0:CH_9]}) begin
      dig_ok  = 1'b1;
      dig_tmp = in_byte - CH_0;
    end else if (hex && (in_byte inside {[CH_LA:CH_LF]})) begin
      dig_ok  = 1'b1;
      dig_tmp = in_byte - CH_LA + 8'd10;
    end else if (hex && (in_byte inside {[CH_UA:CH_UF]})) begin
      dig_ok  = 1'b1;
      dig_tmp = in_byte - CH_UA + 8'd10;
    end
    dig_val  = dig_tmp[3:0];
    num_prod = hex ? 22'({num_r, 4'b0}) : (22'({num_r, 3'b0}) + 22'({num_r, 1'b0}));
    num_sum  = num_prod + 22'(dig_val);
  end

  // Expected byte of the close pattern at the current match position
  always_comb begin
    close_len = (mode_r == MODE_STYLE) ? STYLE_CLOSE_LEN : SCRIPT_CLOSE_LEN;
    close_idx = cpos_r - 3'd1;
    close_ch  = (mode_r == MODE_STYLE) ? STYLE_PAT[close_idx] : SCRIPT_PAT[close_idx];
  end

  // Next state and results for the incoming byte
  always_comb begin
    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    tag_len_nxt  = tag_len_r;
    too_long_nxt = too_long_r;
    cpos_nxt     = cpos_r;
    ent_len_nxt  = ent_len_r;
    num_nxt      = num_r;
    num_done_nxt = num_done_r;
    last_nxt     = last_r;
    in_word_nxt  = in_word_r;
    wt_nxt       = wt_r;
    tag_we       = 1'b0;
    ent_we       = 1'b0;
    do_word      = 1'b0;
    do_space     = 1'b0;
    do_nl        = 1'b0;
    wbyte        = in_byte;

    case (mode_r)
      MODE_TAG: begin
        if (in_byte == CH_GT) begin
          cpos_nxt = 3'd0;
          if (is_script) mode_nxt = MODE_SCRIPT;
          else if (is_style) mode_nxt = MODE_STYLE;
          else begin
            do_nl    = is_break;
            do_space = !is_break;
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          case (phase_r)
            PH_LEAD: begin
              if (in_byte == CH_NUL) phase_nxt = PH_DONE;
              else if (in_byte > CH_SPACE) begin
                phase_nxt = PH_NAME;
                if (tag_len_r < 4'(NAME_DEPTH)) begin
                  tag_we      = 1'b1;
                  tag_len_nxt = tag_len_r + 4'd1;
                end else too_long_nxt = 1'b1;
              end
            end
            PH_NAME: begin
              if (in_byte <= CH_SPACE || in_byte == CH_SLASH) phase_nxt = PH_DONE;
              else if (tag_len_r < 4'(NAME_DEPTH)) begin
                tag_we      = 1'b1;
                tag_len_nxt = tag_len_r + 4'd1;
              end else too_long_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      MODE_SCRIPT, MODE_STYLE: begin
        if (cpos_r == 3'd0) begin
          if (in_byte == CH_LT) cpos_nxt = 3'd1;
        end else if (c_lo == close_ch) begin
          if (cpos_r == close_len) begin
            cpos_nxt = 3'd0;
            mode_nxt = MODE_SKIP_GT;
          end else cpos_nxt = cpos_r + 3'd1;
        end else begin
          cpos_nxt = (in_byte == CH_LT) ? 3'd1 : 3'd0;
        end
      end
      MODE_SKIP_GT: begin
        if (in_byte == CH_GT) mode_nxt = MODE_NORMAL;
      end
      MODE_ENTITY: begin
        if (in_byte == CH_SEMI) begin
          if (dec == CH_SPACE) do_space = 1'b1;
          else if (dec != CH_NUL) begin
            do_word = 1'b1;
            wbyte   = dec;
          end
          mode_nxt = MODE_NORMAL;
        end else if (ent_len_r < ENT_LEN_W'(ENTITY_MAX)) begin
          ent_we      = 1'b1;
          ent_len_nxt = ent_len_r + ENT_LEN_W'(1);
          // accumulate digits of a numeric entity
          if (ent_len_r != '0 && ent_chars_r[0] == CH_HASH &&
              !(ent_len_r == ENT_LEN_W'(1) && is_x) && !num_done_r) begin
            if (!dig_ok) num_done_nxt = 1'b1;
            else num_nxt = (num_sum > 22'(NUM_SAT)) ? NUM_SAT : num_sum[16:0];
          end
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        if (in_byte == CH_LT) begin
          mode_nxt     = MODE_TAG;
          phase_nxt    = PH_LEAD;
          tag_len_nxt  = 4'd0;
          too_long_nxt = 1'b0;
        end else if (in_byte == CH_AMP) begin
          mode_nxt     = MODE_ENTITY;
          ent_len_nxt  = '0;
          num_nxt      = 17'd0;
          num_done_nxt = 1'b0;
        end else if (in_byte <= CH_SPACE) begin
          mode_nxt = MODE_NORMAL;
          do_space = 1'b1;
        end else begin
          mode_nxt = MODE_NORMAL;
          do_word  = 1'b1;
        end
      end
    endcase

    // Apply spacing rules and count words
    p_v = 1'b0;
    p_b = CH_NUL;
    if (do_word) begin
      if (!in_word_r) begin
        if (wt_r != '1) wt_nxt = wt_r + WORD_COUNT_BITS'(1);
        in_word_nxt = 1'b1;
      end
      last_nxt = LAST_TEXT;
      p_v      = 1'b1;
      p_b      = wbyte;
    end
    if (do_space && last_r == LAST_TEXT) begin
      last_nxt    = LAST_SPACE;
      in_word_nxt = 1'b0;
      p_v         = 1'b1;
      p_b         = CH_SPACE;
    end
    if (do_nl && last_r != LAST_NL) begin
      last_nxt    = LAST_NL;
      in_word_nxt = 1'b0;
      p_v         = 1'b1;
      p_b         = CH_NL;
    end

    // Terminator of the final byte
    t_v    = (last_nxt != LAST_NL);
    t_b    = t_v ? CH_NL : CH_NUL;
    wt_ext = 32'(wt_nxt);
    r_p    = '{text_byte: p_b, byte_valid: 1'b1, words: wt_ext[23:0], end_of_text: 1'b0};
    r_t    = '{text_byte: t_b, byte_valid: t_v, words: wt_ext[23:0], end_of_text: 1'b1};
    if (p_v) begin
      emit.r0    = r_p;
      emit.r1    = r_t;
      emit.count = in_is_final ? 2'd2 : 2'd1;
    end else begin
      emit.r0    = r_t;
      emit.r1    = r_t;
      emit.count = in_is_final ? 2'd1 : 2'd0;
    end

    // Return to reset state after the final byte
    if (in_is_final) begin
      mode_nxt     = MODE_NORMAL;
      phase_nxt    = PH_LEAD;
      tag_len_nxt  = 4'd0;
      too_long_nxt = 1'b0;
      cpos_nxt     = 3'd0;
      ent_len_nxt  = '0;
      num_nxt      = 17'd0;
      num_done_nxt = 1'b0;
      last_nxt     = LAST_TEXT;
      in_word_nxt  = 1'b0;
      wt_nxt       = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      phase_r    <= PH_LEAD;
      tag_len_r  <= 4'd0;
      too_long_r <= 1'b0;
      cpos_r     <= 3'd0;
      ent_len_r  <= '0;
      num_r      <= 17'd0;
      num_done_r <= 1'b0;
      last_r     <= LAST_TEXT;
      in_word_r  <= 1'b0;
      wt_r       <= '0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      tag_len_r  <= tag_len_nxt;
      too_long_r <= too_long_nxt;
      cpos_r     <= cpos_nxt;
      ent_len_r  <= ent_len_nxt;
      num_r      <= num_nxt;
      num_done_r <= num_done_nxt;
      last_r     <= last_nxt;
      in_word_r  <= in_word_nxt;
      wt_r       <= wt_nxt;
    end
  end

  // Name and entity byte stores, written at the current length
  always_ff @(posedge clk) begin
    if (accept && tag_we) tag_chars_r[tag_len_r] <= c_lo;
    if (accept && ent_we) ent_chars_r[ent_len_r[ENT_IDX_W-1:0]] <= in_byte;
  end

  `XTP_ASSERT(a_close_pos_in_skip, cpos_r != 3'd0 |-> (mode_r == MODE_SCRIPT || mode_r == MODE_STYLE), "close match position set outside a skipped body")
  `XTP_ASSERT_NEXT(a_final_clears, accept && in_is_final, mode_r == MODE_NORMAL && wt_r == '0 && last_r == LAST_TEXT, "state not cleared after final byte")

endmodule
`default_nettype wire

FILE: design/xhtml_to_plaintext_filter_unit.sv
// Top level of the XHTML to plain-text filter: parser plus output queue.
//
// Usage:
//   Input channel in_valid/in_stall carries one raw XHTML byte (in_byte) and
//   in_is_final, which marks the last byte of a chapter. The output channel
//   out_valid/out_stall carries one text byte per transaction with
//   out_byte_valid, the running word count and out_end_of_text.
//   A byte is decoded in the cycle it is accepted; its results sit in the
//   output queue from the next cycle on. Throughput is one input byte per
//   cycle while in_stall is low. A byte causes up to two results (a final
//   byte adds a terminator); the queue holds three and in_stall rises
//   while more than one result waits, so a byte with two results stalls
//   input even when the receiver takes one result per cycle.
//   When the receiver stalls, the head result holds and the queue absorbs
//   the bytes already accepted; input then stalls.
//   Reset (synchronous, active low) empties the queue and returns the parser
//   to plain-text mode with a zero word count. The final byte of a chapter
//   also returns the parser to that state.
`default_nettype none
`include "assert_macros.svh"
module xhtml_to_plaintext_filter_unit
  import xtp_pkg::*;
#(
  parameter int ENTITY_MAX      = 15,
  parameter int WORD_COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_is_final,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_text_byte,
  output logic             out_byte_valid,
  output logic [23:0]      out_words_so_far,
  output logic             out_end_of_text
);

  localparam int QDEPTH = 3;

  xtp_emit_t   emit;
  xtp_result_t q_r [QDEPTH];
  xtp_result_t q_nxt [QDEPTH];
  logic [1:0]  cnt_r, cnt_nxt, cnt_tmp, push_n;
  logic        accept, pop;

  // Accept while room for a worst-case pair of results
  assign in_stall = (cnt_r > 2'd1);
  assign accept   = in_valid && !in_stall;
  assign pop      = (cnt_r != 2'd0) && !out_stall;
  assign push_n   = accept ? emit.count : 2'd0;

  xtp_parser #(
    .ENTITY_MAX      (ENTITY_MAX),
    .WORD_COUNT_BITS (WORD_COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_is_final (in_is_final),
    .emit        (emit)
  );

  // Advance the queue on a pop, then append this cycle's results
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) q_nxt[i] = q_r[i];
    cnt_tmp = cnt_r;
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_nxt[i] = q_r[i+1];
      cnt_tmp = cnt_r - 2'd1;
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (push_n != 2'd0 && 2'(i) == cnt_tmp) q_nxt[i] = emit.r0;
      if (push_n == 2'd2 && 2'(i) == cnt_tmp + 2'd1) q_nxt[i] = emit.r1;
    end
    cnt_nxt = cnt_tmp + push_n;
  end

  // Queue fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Queue entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q_r[i] <= q_nxt[i];
  end

  assign out_valid        = (cnt_r != 2'd0);
  assign out_text_byte    = q_r[0].text_byte;
  assign out_byte_valid   = q_r[0].byte_valid;
  assign out_words_so_far = q_r[0].words;
  assign out_end_of_text  = q_r[0].end_of_text;

  `XTP_ASSERT(a_queue_no_overflow, (3'(cnt_r) + 3'(push_n) - 3'(pop)) <= 3'(QDEPTH), "output queue overflow")
  `XTP_ASSERT(a_pair_order, (accept && emit.count == 2'd2) |-> (emit.r1.end_of_text && !emit.r0.end_of_text), "terminator not last in result pair")

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the XHTML to plain-text filter unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xtp_pkg::*;

  typedef enum logic [2:0] {
    MODE_TEXT, MODE_IN_TAG, MODE_SCRIPT_BODY, MODE_STYLE_BODY, MODE_IN_ENTITY, MODE_WAIT_GT
  } mode_e;
  typedef enum logic [1:0] {LAST_NONE, LAST_SPACE, LAST_NL} last_e;
  typedef enum logic [1:0] {TP_LEAD, TP_NAME, TP_REST} tag_phase_e;

  localparam int          ENT_DEPTH = 15;
  localparam int unsigned WORD_MAX  = (1 << 24) - 1;
  localparam int          N_BYTES   = 750;

  string BREAK_NAMES [12] = '{"br", "/p", "/div", "/h1", "/h2", "/h3", "/h4", "/h5", "/h6",
                              "/li", "/tr", "/blockquote"};
  string ENT_NAMES [13] = '{"amp", "lt", "gt", "nbsp", "quot", "apos", "mdash", "ndash",
                            "lsquo", "rsquo", "ldquo", "rdquo", "hellip"};
  logic [7:0] ENT_CHARS [13] = '{CH_AMP, CH_LT, CH_GT, CH_SPACE, CH_QUOT, CH_APOS, CH_DASH,
                                 CH_DASH, CH_APOS, CH_APOS, CH_QUOT, CH_QUOT, CH_DOT};
  int unsigned SPECIAL_CPS [9] = '{CP_LSQUO, CP_RSQUO, CP_LDQUO, CP_RDQUO, CP_NDASH,
                                   CP_MDASH, CP_HELLIP, CP_NBSP, CP_PRINT_HI};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_is_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_text_byte;
  logic        out_byte_valid;
  logic [23:0] out_words_so_far;
  logic        out_end_of_text;

  // Raw bytes waiting to be sent: {is_final, byte}
  logic [8:0]  xhtml_q [$];
  xtp_result_t text_exp_q [$];
  int          n_fail = 0;

  // Predictor state
  mode_e       p_mode;
  tag_phase_e  p_phase;
  logic [7:0]  p_tag [NAME_DEPTH];
  int          p_tag_len;
  bit          p_tag_long;
  int          p_cpos;
  logic [7:0]  p_ent [ENT_DEPTH];
  int          p_ent_len;
  int unsigned p_num;
  bit          p_num_done;
  last_e       p_last;
  bit          p_in_word;
  int unsigned p_words;

  // Stimulus and handshake control
  logic [8:0]  drv_item;
  int          in_gap = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          cyc = 0;
  xtp_result_t want;

  xhtml_to_plaintext_filter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_is_final     (in_is_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_text_byte   (out_text_byte),
    .out_byte_valid  (out_byte_valid),
    .out_words_so_far(out_words_so_far),
    .out_end_of_text (out_end_of_text)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] lc(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  function automatic bit tag_is(input string s);
    bit ok;
    ok = !p_tag_long && p_tag_len == s.len();
    for (int k = 0; k < s.len(); k++)
      if (ok && p_tag[k] != s[k]) ok = 1'b0;
    return ok;
  endfunction

  function automatic bit ent_is(input string s);
    bit ok;
    ok = p_ent_len == s.len();
    for (int k = 0; k < s.len(); k++)
      if (ok && p_ent[k] != s[k]) ok = 1'b0;
    return ok;
  endfunction

  function automatic int digit_of(input logic [7:0] c, input bit hex);
    int d;
    d = -1;
    if (c >= CH_0 && c <= CH_9) d = int'(c - CH_0);
    else if (hex && c >= CH_LA && c <= CH_LF) d = int'(c - CH_LA) + 10;
    else if (hex && c >= CH_UA && c <= CH_UF) d = int'(c - CH_UA) + 10;
    return d;
  endfunction

  // Decoded byte of the held entity, NUL when nothing is emitted
  function automatic logic [7:0] entity_value();
    logic [7:0]  d;
    bit          found;
    int unsigned v;
    d = CH_NUL;
    found = 1'b0;
    v = p_num;
    for (int k = 0; k < 13; k++)
      if (!found && ent_is(ENT_NAMES[k])) begin
        d = ENT_CHARS[k];
        found = 1'b1;
      end
    if (!found && p_ent_len != 0 && p_ent[0] == CH_HASH) begin
      if (v >= CP_PRINT_LO && v < CP_PRINT_HI) d = v[7:0];
      else if (v == CP_LSQUO || v == CP_RSQUO) d = CH_APOS;
      else if (v == CP_LDQUO || v == CP_RDQUO) d = CH_QUOT;
      else if (v == CP_NDASH || v == CP_MDASH) d = CH_DASH;
      else if (v == CP_HELLIP) d = CH_DOT;
      else if (v == CP_NBSP) d = CH_SPACE;
    end
    return d;
  endfunction

  task automatic clear_state();
    p_mode = MODE_TEXT;
    p_phase = TP_LEAD;
    for (int k = 0; k < NAME_DEPTH; k++) p_tag[k] = 8'h00;
    for (int k = 0; k < ENT_DEPTH; k++) p_ent[k] = 8'h00;
    p_tag_len = 0;
    p_tag_long = 1'b0;
    p_cpos = 0;
    p_ent_len = 0;
    p_num = 0;
    p_num_done = 1'b0;
    p_last = LAST_NONE;
    p_in_word = 1'b0;
    p_words = 0;
  endtask

  task automatic push_text(input logic [7:0] b, input logic v, input logic eot);
    xtp_result_t r;
    r.text_byte = b;
    r.byte_valid = v;
    r.words = p_words[23:0];
    r.end_of_text = eot;
    text_exp_q.push_back(r);
  endtask

  task automatic add_word(input logic [7:0] c);
    if (!p_in_word) begin
      if (p_words < WORD_MAX) p_words++;
      p_in_word = 1'b1;
    end
    p_last = LAST_NONE;
    push_text(c, 1'b1, 1'b0);
  endtask

  task automatic add_space();
    if (p_last == LAST_NONE) begin
      p_last = LAST_SPACE;
      p_in_word = 1'b0;
      push_text(CH_SPACE, 1'b1, 1'b0);
    end
  endtask

  task automatic add_line_break();
    if (p_last != LAST_NL) begin
      p_last = LAST_NL;
      p_in_word = 1'b0;
      push_text(CH_NL, 1'b1, 1'b0);
    end
  endtask

  task automatic tag_append(input logic [7:0] c);
    if (p_tag_len < NAME_DEPTH) begin
      p_tag[p_tag_len] = c;
      p_tag_len++;
    end else begin
      p_tag_long = 1'b1;
    end
  endtask

  // Collect the tag name: skip leading blanks, stop at blank, slash or NUL
  task automatic tag_byte(input logic [7:0] c);
    case (p_phase)
      TP_LEAD: begin
        if (c == CH_NUL) p_phase = TP_REST;
        else if (c > CH_SPACE) begin
          p_phase = TP_NAME;
          tag_append(lc(c));
        end
      end
      TP_NAME: begin
        if (c <= CH_SPACE || c == CH_SLASH) p_phase = TP_REST;
        else tag_append(lc(c));
      end
      default: ;
    endcase
  endtask

  task automatic tag_finish();
    bit brk;
    brk = 1'b0;
    p_cpos = 0;
    if (tag_is("script")) p_mode = MODE_SCRIPT_BODY;
    else if (tag_is("style")) p_mode = MODE_STYLE_BODY;
    else begin
      for (int k = 0; k < 12; k++)
        if (tag_is(BREAK_NAMES[k])) brk = 1'b1;
      if (brk) add_line_break();
      else add_space();
      p_mode = MODE_TEXT;
    end
  endtask

  // Track a case-insensitive close pattern inside a skipped body
  task automatic skip_body(input logic [7:0] c, input string pat);
    if (p_cpos == 0) begin
      if (c == CH_LT) p_cpos = 1;
    end else if (p_cpos <= pat.len() && lc(c) == pat[p_cpos-1]) begin
      if (p_cpos == pat.len()) begin
        p_cpos = 0;
        p_mode = MODE_WAIT_GT;
      end else begin
        p_cpos++;
      end
    end else begin
      p_cpos = (c == CH_LT) ? 1 : 0;
    end
  endtask

  task automatic entity_push(input logic [7:0] c);
    bit          hex;
    int          d;
    int unsigned v;
    if (p_ent_len > 0 && p_ent[0] == CH_HASH) begin
      hex = p_ent_len >= 2 && (p_ent[1] == CH_LX || p_ent[1] == CH_UX);
      if (!(p_ent_len == 1 && (c == CH_LX || c == CH_UX)) && !p_num_done) begin
        d = digit_of(c, hex);
        if (d < 0) begin
          p_num_done = 1'b1;
        end else begin
          v = p_num * (hex ? 16 : 10) + d;
          p_num = (v > NUM_SAT) ? NUM_SAT : v;
        end
      end
    end
    p_ent[p_ent_len] = c;
    p_ent_len++;
  endtask

  // Advance the filter by one accepted byte and queue the text it yields
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    logic [7:0] d;
    case (p_mode)
      MODE_IN_TAG: begin
        if (c == CH_GT) tag_finish();
        else tag_byte(c);
      end
      MODE_SCRIPT_BODY: skip_body(c, "/script");
      MODE_STYLE_BODY:  skip_body(c, "/style");
      MODE_WAIT_GT: begin
        if (c == CH_GT) p_mode = MODE_TEXT;
      end
      MODE_IN_ENTITY: begin
        if (c == CH_SEMI) begin
          d = entity_value();
          if (d == CH_SPACE) add_space();
          else if (d != CH_NUL) add_word(d);
          p_mode = MODE_TEXT;
        end else if (p_ent_len < ENT_DEPTH) begin
          entity_push(c);
        end else begin
          p_mode = MODE_TEXT;
        end
      end
      default: begin
        if (c == CH_LT) begin
          p_mode = MODE_IN_TAG;
          p_phase = TP_LEAD;
          p_tag_len = 0;
          p_tag_long = 1'b0;
        end else if (c == CH_AMP) begin
          p_mode = MODE_IN_ENTITY;
          p_ent_len = 0;
          p_num = 0;
          p_num_done = 1'b0;
        end else if (c <= CH_SPACE) begin
          add_space();
        end else begin
          add_word(c);
        end
      end
    endcase
    // Close the chapter with a terminator and start over
    if (fin) begin
      if (p_last != LAST_NL) push_text(CH_NL, 1'b1, 1'b1);
      else push_text(CH_NUL, 1'b0, 1'b1);
      clear_state();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic put_b(input logic [7:0] b);
    xhtml_q.push_back({1'b0, b});
  endtask

  task automatic put_s(input string s);
    for (int k = 0; k < s.len(); k++) put_b(s[k]);
  endtask

  task automatic mark_final();
    logic [8:0] t;
    t = xhtml_q.pop_back();
    t[8] = 1'b1;
    xhtml_q.push_back(t);
  endtask

  function automatic string mixcase(input string s);
    string r;
    r = s;
    for (int k = 0; k < r.len(); k++)
      if (r[k] >= "a" && r[k] <= "z" && $urandom_range(0, 1)) r[k] = r[k] - 8'd32;
    return r;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] b;
    b = CH_LA + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 3) == 0) b = b - 8'd32;
    return b;
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(128, 255));
    do b = 8'($urandom_range(33, 126)); while (b == CH_LT || b == CH_AMP);
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = CH_SPACE;
      1: b = CH_NL;
      2: b = 8'h09;
      default: b = 8'($urandom_range(0, 32));
    endcase
    return b;
  endfunction

  // Append one random markup fragment, mostly well formed
  task automatic gen_fragment();
    int          n;
    int unsigned v;
    string       s;
    string       body;
    bit          hex;
    case ($urandom_range(0, 11))
      0, 1, 2: repeat ($urandom_range(1, 6)) put_b(word_byte());
      3: repeat ($urandom_range(1, 3)) put_b(space_byte());
      4: begin
        s = "<";
        if ($urandom_range(0, 3) == 0) s = {s, " "};
        s = {s, mixcase(BREAK_NAMES[$urandom_range(0, 11)])};
        if ($urandom_range(0, 2) == 0) s = {s, " class=\"c\""};
        if ($urandom_range(0, 3) == 0) s = {s, "/"};
        put_s({s, ">"});
      end
      5: begin
        // Arbitrary tag, sometimes too long or cut by a NUL
        put_b(CH_LT);
        if ($urandom_range(0, 1)) put_b(CH_SLASH);
        n = $urandom_range(1, 14);
        for (int k = 0; k < n; k++) begin
          if (k == n / 2 && $urandom_range(0, 4) == 0) put_b(CH_NUL);
          put_b(rand_letter());
        end
        if ($urandom_range(0, 2) == 0) put_s(" a='&x<'");
        put_b(CH_GT);
      end
      6: begin
        s = $urandom_range(0, 1) ? "script" : "style";
        put_s({"<", mixcase(s)});
        if ($urandom_range(0, 1)) put_s(" type=\"t\"");
        put_b(CH_GT);
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(0, 4))
            0: put_b(CH_LT);
            1: begin
              body = s.substr(0, $urandom_range(0, s.len() - 2));
              put_s({"</", mixcase(body)});
            end
            2: put_b(8'($urandom_range(0, 255)));
            default: put_b(rand_letter());
          endcase
        end
        put_s({"</", mixcase(s)});
        if ($urandom_range(0, 2) == 0) put_s(" x");
        put_b(CH_GT);
      end
      7: begin
        s = ENT_NAMES[$urandom_range(0, 12)];
        if ($urandom_range(0, 4) == 0) s = mixcase(s);
        put_s({"&", s, ";"});
      end
      8: begin
        // Numeric entity: printable, typographic, control or oversized value
        case ($urandom_range(0, 3))
          0: v = $urandom_range(32, 126);
          1: v = SPECIAL_CPS[$urandom_range(0, 8)];
          2: v = $urandom_range(0, 200000);
          default: v = $urandom_range(0, 160);
        endcase
        hex = 1'($urandom_range(0, 1));
        if (hex) s = mixcase($sformatf("%0h", v));
        else s = $sformatf("%0d", v);
        if ($urandom_range(0, 5) == 0) s = "";
        if ($urandom_range(0, 4) == 0) s = {"0", s};
        if ($urandom_range(0, 5) == 0) s = {s, "g"};
        put_s("&#");
        if (hex) put_b($urandom_range(0, 1) ? CH_LX : CH_UX);
        put_s({s, ";"});
      end
      9: begin
        // Unknown or overlong entity
        put_b(CH_AMP);
        repeat ($urandom_range(1, 18)) put_b(rand_letter());
        if ($urandom_range(0, 1)) put_b(CH_SEMI);
      end
      10: repeat ($urandom_range(1, 4)) put_b(8'($urandom_range(0, 255)));
      default: begin
        put_b(8'($urandom_range(0, 255)));
        mark_final();
      end
    endcase
    if ($urandom_range(0, 14) == 0) mark_final();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_error(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------- handshakes

  // Drive input transactions from the byte queue, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
      in_is_final <= 1'b0;
      in_gap = 0;
      calm <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte, in_is_final);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (xhtml_q.size() > 0) begin
          drv_item = xhtml_q.pop_front();
          in_byte <= drv_item[7:0];
          in_is_final <= drv_item[8];
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm <= (xhtml_q.size() < 100);
    end
  end

  // Hold off the receiver for a long stretch once, early in the run
  always @(posedge clk) begin
    if (!rst_n) begin
      cyc = 0;
      hold_left <= 0;
    end else begin
      cyc++;
      if (cyc == 300) hold_left <= 150;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  // Stall the output in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each output transaction with the oldest expected text byte
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (text_exp_q.size() == 0) begin
        flag_error($sformatf("unexpected output: byte %02h valid %0b words %0d end %0b",
                             out_text_byte, out_byte_valid, out_words_so_far,
                             out_end_of_text));
      end else begin
        want = text_exp_q.pop_front();
        if (out_text_byte !== want.text_byte || out_byte_valid !== want.byte_valid ||
            out_words_so_far !== want.words || out_end_of_text !== want.end_of_text)
          flag_error($sformatf({"expected byte %02h valid %0b words %0d end %0b, ",
                                "got byte %02h valid %0b words %0d end %0b"},
                               want.text_byte, want.byte_valid, want.words,
                               want.end_of_text, out_text_byte, out_byte_valid,
                               out_words_so_far, out_end_of_text));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int drain;
    clear_state();
    // Directed: byte extremes, break tag, named and numeric entities, both terminators
    put_b(8'hFF);
    put_b(CH_NUL);
    put_b(CH_UA);
    put_s("<br>");
    put_s("&lt;");
    put_s("&#x41;");
    mark_final();
    put_s("b</p>");
    mark_final();
    while (xhtml_q.size() < N_BYTES) gen_fragment();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to be accepted, then for the text to drain
    do @(negedge clk); while (xhtml_q.size() != 0 || in_valid);
    for (drain = 0; drain < 1000 && text_exp_q.size() != 0; drain++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (text_exp_q.size() != 0)
      flag_error($sformatf("%0d expected text bytes never arrived", text_exp_q.size()));

    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/xtp_pkg.sv
design/xtp_parser.sv
design/xhtml_to_plaintext_filter_unit.sv
test/tb.sv
